// ===== rtl/dde_pkg.sv =====
package dde_pkg;

    localparam int unsigned BIN_W       = 32;
    localparam int unsigned BCD_DIGITS  = 10;
    localparam int unsigned BCD_W       = 4 * BCD_DIGITS;
    localparam int unsigned DD_STAGES   = 4;
    localparam int unsigned DD_STEPS    = BIN_W / DD_STAGES;

    localparam logic [BIN_W-1:0] WRAP_LIMIT = 32'd99999999;
    localparam logic [BIN_W-1:0] WRAP_STEP  = 32'd100000000;
    localparam logic [3:0]       BLANK_CODE = 4'hF;

    typedef logic [BIN_W-1:0] t_bin;
    typedef logic [BCD_W-1:0] t_bcd;
    typedef logic [3:0]       t_code;

    // partial double-dabble state carried between stages
    typedef struct packed {
        t_bcd bcd;
        t_bin bin;
    } t_dd;

endpackage

// ===== rtl/decimal_display_digit_encoder_core.sv =====
// Decimal display digit encoder.
//
// Input channel (i_valid / o_stall): one 32-bit unsigned number per word.
// Numbers above 99,999,999 have 100,000,000 taken off once. The number is
// then turned into decimal and sent out as DIGIT_COUNT words on the output
// channel (o_valid / i_stall), least significant position first. Each word
// carries the position (1..DIGIT_COUNT), the digit or the blank code 15 for
// leading zeros (position 1 of a zero shows 0), and a last flag on the final
// position.
//
// Pipeline: a wrap subtract register, four double-dabble stages (eight bit
// steps each), then the digit shift register.
// Throughput: the digit shift register drains one word per cycle while
// i_stall is low and loads the next number as its last word is taken; the
// pipeline in front holds up to five further numbers, so input words are
// taken while digits still drain.
// Reset (i_rst_n low, synchronous) empties every stage. When i_stall is high
// the current digit word holds and the pipeline fills up behind it; o_stall
// rises only when every stage is occupied. Nothing is dropped or repeated.
module decimal_display_digit_encoder_core
    import dde_pkg::*;
#(
    parameter int unsigned DIGIT_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [31:0] i_number_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_digit_position,
    output logic [3:0] o_digit_code,
    output logic       o_last_digit
);

    localparam int unsigned CW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    // eight double-dabble steps: add 3 to nibbles >= 5, shift left
    function automatic t_dd dd_steps(input t_dd din);
        t_dd d;
        d = din;
        for (int s = 0; s < DD_STEPS; s++) begin
            for (int k = 0; k < BCD_DIGITS; k++) begin
                if (d.bcd[4*k +: 4] >= 4'd5) begin
                    d.bcd[4*k +: 4] = d.bcd[4*k +: 4] + 4'd3;
                end
            end
            d = {d[BCD_W+BIN_W-2:0], 1'b0};
        end
        return d;
    endfunction

    // wrap stage
    logic r_wrap_vld;
    t_bin r_wrap;
    logic w_wrap_rdy;

    // conversion stages
    logic [DD_STAGES-1:0] r_dd_vld;
    t_dd                  r_dd [DD_STAGES];
    t_dd                  n_dd [DD_STAGES];
    logic [DD_STAGES-1:0] w_dd_rdy;

    // digit shift register
    logic          r_ser_vld;
    logic [CW-1:0] r_cnt;
    t_code         r_codes [DIGIT_COUNT];
    t_code         n_codes [DIGIT_COUNT];
    logic          w_ser_rdy;
    logic          w_last;
    logic          w_out_acc;
    logic [BCD_DIGITS-1:0] w_any;

    assign w_last    = (r_cnt == CW'(DIGIT_COUNT - 1));
    assign w_out_acc = r_ser_vld && !i_stall;
    assign w_ser_rdy = !r_ser_vld || (w_out_acc && w_last);

    // ready chain, back to front
    always_comb begin
        w_dd_rdy[DD_STAGES-1] = !r_dd_vld[DD_STAGES-1] || w_ser_rdy;
        for (int k = DD_STAGES - 2; k >= 0; k--) begin
            w_dd_rdy[k] = !r_dd_vld[k] || w_dd_rdy[k+1];
        end
    end
    assign w_wrap_rdy = !r_wrap_vld || w_dd_rdy[0];
    assign o_stall    = !w_wrap_rdy;

    // stage inputs
    always_comb begin
        n_dd[0] = dd_steps('{bcd: '0, bin: r_wrap});
        for (int k = 1; k < DD_STAGES; k++) begin
            n_dd[k] = dd_steps(r_dd[k-1]);
        end
    end

    // blanking: digit shown when it or any higher digit is nonzero; the lowest digit is always shown
    always_comb begin
        w_any[BCD_DIGITS-1] = |r_dd[DD_STAGES-1].bcd[4*(BCD_DIGITS-1) +: 4];
        for (int k = BCD_DIGITS - 2; k >= 0; k--) begin
            w_any[k] = w_any[k+1] || (|r_dd[DD_STAGES-1].bcd[4*k +: 4]);
        end
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            if (k == 0 || w_any[k]) begin
                n_codes[k] = r_dd[DD_STAGES-1].bcd[4*k +: 4];
            end else begin
                n_codes[k] = BLANK_CODE;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_vld <= 1'b0;
            r_dd_vld   <= '0;
            r_ser_vld  <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (w_wrap_rdy) begin
                r_wrap_vld <= i_valid;
            end
            if (w_dd_rdy[0]) begin
                r_dd_vld[0] <= r_wrap_vld;
            end
            for (int k = 1; k < DD_STAGES; k++) begin
                if (w_dd_rdy[k]) begin
                    r_dd_vld[k] <= r_dd_vld[k-1];
                end
            end
            if (w_ser_rdy) begin
                r_ser_vld <= r_dd_vld[DD_STAGES-1];
                r_cnt     <= '0;
            end else if (w_out_acc) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_wrap_rdy) begin
            r_wrap <= (i_number_value > WRAP_LIMIT) ? i_number_value - WRAP_STEP
                                                    : i_number_value;
        end
        if (w_dd_rdy[0]) begin
            r_dd[0] <= n_dd[0];
        end
        for (int k = 1; k < DD_STAGES; k++) begin
            if (w_dd_rdy[k]) begin
                r_dd[k] <= n_dd[k];
            end
        end
        if (w_ser_rdy) begin
            r_codes <= n_codes;
        end else if (w_out_acc) begin
            for (int k = 0; k < DIGIT_COUNT - 1; k++) begin
                r_codes[k] <= r_codes[k+1];
            end
        end
    end

    assign o_valid          = r_ser_vld;
    assign o_digit_code     = r_codes[0];
    assign o_digit_position = 4'(r_cnt) + 4'd1;
    assign o_last_digit     = w_last;

    // positions count up within a run
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_digit) |=>
            (o_valid && o_digit_position == $past(o_digit_position) + 4'd1))
        else $error("digit position did not advance");

    // once blank, higher positions of the same run stay blank
    a_blank_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_digit && o_digit_code == BLANK_CODE) |=>
            (o_digit_code == BLANK_CODE))
        else $error("digit after a blank is not blank");

    // codes are decimal digits or blank
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_code <= 4'd9 || o_digit_code == BLANK_CODE))
        else $error("bad digit code");

    // position 1 is never blank
    a_first_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_digit_position == 4'd1) |-> (o_digit_code != BLANK_CODE))
        else $error("least significant digit blanked");

endmodule

// ===== verif/decimal_display_digit_encoder_core_tb.sv =====
module decimal_display_digit_encoder_core_tb
    import dde_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Eight display positions, as in the shipped configuration.
    localparam int unsigned DIGITS      = 8;
    localparam int unsigned RADIX       = 10;
    localparam int unsigned RESET_TICKS = 12;
    // Settle time after the last digit word: covers the wrap, double-dabble and
    // digit register stages plus the drain of one full digit shift register, with room to spare.
    localparam int unsigned DRAIN_TICKS = 40;
    // Worst case is roughly 300 numbers x 8 words, each word held by a stall
    // burst, plus sender gaps. Several times that is still far below this.
    localparam int unsigned CYCLE_LIMIT = 200000;

    // One digit word as seen on the output channel.
    typedef struct packed {
        t_code position;
        t_code code;
        logic  last;
    } t_digit_word;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [31:0] i_number_value = '0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_digit_position;
    logic [3:0]  o_digit_code;
    logic        o_last_digit;

    // Expected digit words, oldest first.
    t_digit_word pending_digits[$];

    int unsigned numbers_sent   = 0;
    int unsigned digits_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Random idling switches for the two sides.
    bit src_idle_on  = 1'b0;
    bit sink_idle_on = 1'b0;
    int unsigned sink_hold = 0;

    decimal_display_digit_encoder_core #(
        .DIGIT_COUNT(DIGITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_number_value  (i_number_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_digit_position(o_digit_position),
        .o_digit_code    (o_digit_code),
        .o_last_digit    (o_last_digit)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d digit words outstanding",
                     cycle_count, pending_digits.size());
            $display("decimal_display_digit_encoder_core_tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Works out the digit words one number should produce: a single wrap of
    // 100,000,000 above 99,999,999, then each position either shows its
    // decimal digit or blanks when the value is below that position's weight.
    // A zero still shows 0 in the lowest position.
    function automatic void predict_digits(input t_bin number);
        t_bin            folded;
        longint unsigned weight;
        t_digit_word     w;
        folded = number;
        if (folded > WRAP_LIMIT)
            folded = folded - WRAP_STEP;
        weight = 1;
        for (int p = 1; p <= DIGITS; p++) begin
            w.position = t_code'(p);
            if (folded >= weight)
                w.code = t_code'((folded / weight) % RADIX);
            else if (folded == 0 && p == 1)
                w.code = '0;
            else
                w.code = BLANK_CODE;
            w.last = (p == DIGITS);
            pending_digits.push_back(w);
            weight = weight * RADIX;
        end
    endfunction

    // Sends one number. Valid is left high after acceptance so back-to-back
    // numbers never see valid dropped and raised in the same step; it only
    // goes low for a source gap or at the end of the run.
    task automatic send_number(input t_bin number);
        int unsigned gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_number_value <= number;
        do @(posedge i_clk); while (o_stall);
        predict_digits(number);
        numbers_sent++;
    endtask

    // Sink side: stall in random bursts when enabled.
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold--;
            i_stall <= 1'b1;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            sink_hold = $urandom_range(1, 10) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Digit word checker: every accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        t_digit_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_digits.size() == 0) begin
                report_mismatch($sformatf("unexpected word pos=%0d code=%0d last=%0b",
                                          o_digit_position, o_digit_code, o_last_digit));
            end else begin
                want = pending_digits.pop_front();
                if (o_digit_position !== want.position)
                    report_mismatch($sformatf("position got %0d want %0d",
                                              o_digit_position, want.position));
                if (o_digit_code !== want.code)
                    report_mismatch($sformatf("pos %0d code got %0d want %0d",
                                              want.position, o_digit_code, want.code));
                if (o_last_digit !== want.last)
                    report_mismatch($sformatf("pos %0d last got %0b want %0b",
                                              want.position, o_last_digit, want.last));
                digits_checked++;
            end
        end
    end

    // Zero, single digits and decade edges below the wrap point.
    task automatic test_small_values();
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'd9);
        send_number(32'd10);
        send_number(32'd9999999);
        send_number(32'd10000000);
        send_number(32'd12345678);
        send_number(WRAP_LIMIT);
    endtask

    // Around the single subtraction: 10^8 folds to zero, 2*10^8 folds to a
    // value that still has a ninth digit, so all eight low digits show.
    task automatic test_wrap_boundary();
        send_number(WRAP_STEP);
        send_number(WRAP_STEP + 32'd1);
        send_number(32'd199999999);
        send_number(32'd200000000);
        send_number(32'd200000001);
        send_number(32'd1000000000);
    endtask

    // Full-range values, including every bit high and alternating patterns.
    task automatic test_large_values();
        send_number(32'hFFFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'h5555_5555);
        send_number(32'hAAAA_AAAA);
        send_number(32'h0000_FFFF);
    endtask

    // Random numbers spread over all magnitudes; idling toggles in stretches.
    task automatic test_random_mix(input int unsigned count);
        t_bin        number;
        int unsigned decade;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 4))
                0: number = $urandom;
                1: begin
                    // below 10^decade, so blanking starts at a random position
                    decade = $urandom_range(0, 8);
                    number = $urandom_range(0, (10 ** decade) - 1);
                end
                2: number = WRAP_STEP + $urandom_range(0, WRAP_LIMIT);
                3: begin
                    // powers of ten and their neighbours
                    decade = $urandom_range(0, 9);
                    number = t_bin'(10 ** decade) + t_bin'($urandom_range(0, 2)) - 32'd1;
                end
                default: number = $urandom_range(0, 999);
            endcase
            send_number(number);
        end
    endtask

    // Closing stretch at full rate, no idling on either side.
    task automatic test_back_to_back(input int unsigned count);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (int unsigned n = 0; n < count; n++)
            send_number($urandom);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_values();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        test_wrap_boundary();
        test_large_values();
        test_random_mix(220);
        test_back_to_back(30);

        i_valid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);
        if (pending_digits.size() != 0)
            report_mismatch($sformatf("%0d digit words never arrived",
                                      pending_digits.size()));

        $display("Sent %0d numbers (zero, decade edges, wrap fold, full range, random)",
                 numbers_sent);
        $display("Checked %0d digit words under random stalls, %0d mismatches",
                 digits_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("decimal_display_digit_encoder_core_tb OK");
        end else begin
            $display("decimal_display_digit_encoder_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dde_pkg.sv
rtl/decimal_display_digit_encoder_core.sv
verif/decimal_display_digit_encoder_core_tb.sv
